// ===== rtl/hsvnc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvnc_pkg
// Shared types and constants for the HSV nearest-sample pixel classifier.
// ----------------------------------------------------------------------------
package hsvnc_pkg;

  localparam int WEIGHT_W  = 12;
  localparam int FILTER_W  = 13;
  localparam int PROD_W    = 20;  // 12-bit weight times 8-bit difference
  localparam int DIST_W    = 22;  // sum of three products, units of 1/256
  localparam int FRAC_W    = 8;   // fraction bits of a weight and a distance
  localparam int PROB_W    = 17;
  localparam int RND_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 17;  // one quotient bit per step
  localparam int DIV_CNT_W = 5;

  localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT         = 12'd256;
  localparam logic [FILTER_W-1:0] DEFAULT_FILTER_SIZE = 13'd50;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_CLASSIFY = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_HUE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SATURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_VALUE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE       = 2'd3;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       hue;
    logic [7:0]       saturation;
    logic [7:0]       brightness;
    logic [RND_W-1:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic                selected;
    logic [PROB_W-1:0]   probability;
    logic [FILTER_W-1:0] min_distance;
    logic                table_full;
  } out_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] hue;
    logic [WEIGHT_W-1:0] saturation;
    logic [WEIGHT_W-1:0] brightness;
  } weights_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/hsvnc_sample_mem.sv =====
// ----------------------------------------------------------------------------
// hsvnc_sample_mem
// Sample table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hsvnc_sample_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  hsvnc_pkg::hsv_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output hsvnc_pkg::hsv_t rd_data
);
  import hsvnc_pkg::*;

  hsv_t mem [DEPTH];
  hsv_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/hsvnc_dist.sv =====
// ----------------------------------------------------------------------------
// hsvnc_dist
// Two-stage weighted L1 distance: products registered, then their sum.
// ----------------------------------------------------------------------------
module hsvnc_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  hsvnc_pkg::hsv_t              pixel,
  input  hsvnc_pkg::hsv_t              sample,
  input  hsvnc_pkg::weights_t          weights,
  output logic                         dist_vld,
  output logic [hsvnc_pkg::DIST_W-1:0] dist_sum,
  output logic                         busy
);
  import hsvnc_pkg::*;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  logic              s1_vld_r;
  logic              s2_vld_r;
  logic [PROD_W-1:0] prod_h_r;
  logic [PROD_W-1:0] prod_s_r;
  logic [PROD_W-1:0] prod_v_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] dist_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_h_r <= PROD_W'(weights.hue) * PROD_W'(absdiff(pixel.hue, sample.hue));
    prod_s_r <= PROD_W'(weights.saturation) *
                PROD_W'(absdiff(pixel.saturation, sample.saturation));
    prod_v_r <= PROD_W'(weights.brightness) *
                PROD_W'(absdiff(pixel.brightness, sample.brightness));
  end

  assign dist_nxt = DIST_W'(prod_h_r) + DIST_W'(prod_s_r) + DIST_W'(prod_v_r);

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  assign dist_vld = s2_vld_r;
  assign dist_sum = dist_r;
  assign busy     = s1_vld_r | s2_vld_r;

endmodule

// ===== rtl/hsvnc_div.sv =====
// ----------------------------------------------------------------------------
// hsvnc_div
// Restoring divider: quotient = dividend * 65536 / divisor, one bit a cycle.
// Requires dividend <= divisor, so the quotient fits 17 bits.
// ----------------------------------------------------------------------------
module hsvnc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [hsvnc_pkg::FILTER_W-1:0] dividend,
  input  logic [hsvnc_pkg::FILTER_W-1:0] divisor,
  output logic                           done,
  output logic [hsvnc_pkg::PROB_W-1:0]   quotient
);
  import hsvnc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [FILTER_W-1:0]  rem_r;
  logic [FILTER_W-1:0]  rem_nxt;
  logic [PROB_W-1:0]    q_r;
  logic [FILTER_W:0]    shifted;
  logic [FILTER_W:0]    diff;
  logic                 ge;

  always_comb begin
    // first step tests the dividend itself, later steps bring in a zero bit
    shifted = (cnt_r == DIV_CNT_W'(DIV_STEPS)) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
    rem_nxt = ge ? diff[FILTER_W-1:0] : shifted[FILTER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[PROB_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/hsv_nearest_sample_pixel_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_nearest_sample_pixel_classifier_unit
// Classifies HSV pixels by weighted L1 distance to a table of stored samples.
// Add, clear and unused-mode items go straight to the done state, which loads
// their result into the output register once it is free. A classify item
// scans the stored samples, drains the distance pipeline and then, unless no
// sample lies closer than the filter size, runs the divider before the done
// state: the sample memory gives one entry per cycle to a two-stage distance
// unit, and the probability then comes from a 17-step divider. One item is
// worked on at a time; the next input transfer is taken the cycle after the
// result is loaded into the output register, so a held output stalls the
// input. No clearing pass is needed after reset. Weights and filter size are
// written through cfg_*.
// ----------------------------------------------------------------------------
module hsv_nearest_sample_pixel_classifier_unit #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hsvnc_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hsvnc_pkg::out_item_t            out_data,
  input  logic                            cfg_we,
  input  logic [hsvnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsvnc_pkg::FILTER_W-1:0]  cfg_wdata
);
  import hsvnc_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  state_t              state_r, state_nxt;
  logic [WEIGHT_W-1:0] wh_r, ws_r, wv_r;
  logic [FILTER_W-1:0] fs_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  hsv_t                pix_r, pix_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_data_r;
  logic                out_valid_r;
  logic                rd_vld_r;

  logic                in_xfer;
  logic                mem_we;
  logic                rd_issue;
  logic                div_start;
  logic                out_load;
  hsv_t                wr_sample;
  hsv_t                rd_sample;
  weights_t            weights;
  logic                dist_vld;
  logic [DIST_W-1:0]   dist_sum;
  logic                dist_busy;
  logic                div_done;
  logic [PROB_W-1:0]   quotient;
  logic [DIST_W-FRAC_W-1:0] mind_w;
  logic [FILTER_W-1:0] div_num;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign wr_sample = '{hue: in_data.hue, saturation: in_data.saturation,
                       brightness: in_data.brightness};
  assign weights   = '{hue: wh_r, saturation: ws_r, brightness: wv_r};
  assign mind_w    = best_r[DIST_W-1:FRAC_W];
  assign div_num   = fs_r - mind_w[FILTER_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r <= UNIT_WEIGHT;
      ws_r <= UNIT_WEIGHT;
      wv_r <= UNIT_WEIGHT;
      fs_r <= DEFAULT_FILTER_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_HUE:        wh_r <= cfg_wdata[WEIGHT_W-1:0];
        REG_WEIGHT_SATURATION: ws_r <= cfg_wdata[WEIGHT_W-1:0];
        REG_WEIGHT_VALUE:      wv_r <= cfg_wdata[WEIGHT_W-1:0];
        REG_FILTER_SIZE:       fs_r <= (cfg_wdata == '0) ? FILTER_W'(1) : cfg_wdata;
        default: ;
      endcase
    end
  end

  hsvnc_sample_mem #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_sample),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_sample)
  );

  hsvnc_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rd_vld_r),
    .pixel    (pix_r),
    .sample   (rd_sample),
    .weights  (weights),
    .dist_vld (dist_vld),
    .dist_sum (dist_sum),
    .busy     (dist_busy)
  );

  hsvnc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (fs_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    pix_nxt   = pix_r;
    rnd_nxt   = rnd_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    rd_issue  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;

    // running minimum over distances leaving the pipeline
    if (dist_vld && (dist_sum < best_r)) begin
      best_nxt = dist_sum;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
          case (in_data.mode)
            MODE_ADD: begin
              if (count_r == CW'(MAX_SAMPLES)) begin
                res_nxt.table_full = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            MODE_CLASSIFY: begin
              pix_nxt   = wr_sample;
              rnd_nxt   = in_data.random_fraction;
              best_nxt  = DIST_W'({fs_r, {FRAC_W{1'b0}}});
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_r < count_r) begin
          rd_issue = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !dist_busy) begin
          if (mind_w >= (DIST_W-FRAC_W)'(fs_r)) begin
            res_nxt.min_distance = fs_r;
            state_nxt            = ST_DONE;
          end else begin
            res_nxt.min_distance = mind_w[FILTER_W-1:0];
            div_start            = 1'b1;
            state_nxt            = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt.probability = quotient;
          res_nxt.selected    = quotient > PROB_W'(rnd_r);
          state_nxt           = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_issue;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    pix_r  <= pix_nxt;
    rnd_r  <= rnd_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("sample count beyond table depth");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("memory read returned outside of a scan");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside of the divide state");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> best_r <= DIST_W'({fs_r, {FRAC_W{1'b0}}}))
    else $error("running minimum above the filter size");

  a_classify_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.mode == MODE_CLASSIFY) |=> state_r == ST_SCAN)
    else $error("classify transfer did not start a scan");

endmodule

// ===== sim/tb_hsv_nearest_sample_pixel_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_nearest_sample_pixel_classifier_unit
// Drives add, clear, classify and reserved-mode items and checks each result
// against its typed row value or a built-in nearest-sample predictor. Runs a
// directed table first, then random sample sets under several weight and
// filter settings, with random gaps, stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_hsv_nearest_sample_pixel_classifier_unit;
  import hsvnc_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASE_ITEMS    = 92;
  localparam int IDLE_GUARD     = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 300;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FILTER_W-1:0]  cfg_wdata;

  // predictor state
  int unsigned w_hue      = 256;
  int unsigned w_sat      = 256;
  int unsigned w_val      = 256;
  int unsigned filter_len = 50;
  hsv_t        sample_mirror [TABLE_DEPTH];
  int unsigned stored_count = 0;

  out_item_t     pending_outcomes [$];
  directed_row_t directed_rows [$];
  int            accepted_items = 0;
  int            results_seen   = 0;
  int            fails          = 0;
  int            cycle_count    = 0;
  bit            steady         = 1'b0;

  hsv_nearest_sample_pixel_classifier_unit #(
    .MAX_SAMPLES(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL hsv_nearest_sample_pixel_classifier_unit");
    $finish;
  end

  function automatic int unsigned chan_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // Advance the mirrored table and work out the result of one transfer.
  function automatic out_item_t nearest_sample_outcome(input in_item_t px);
    out_item_t       r;
    int unsigned     best;
    int unsigned     d;
    int unsigned     mind;
    longint unsigned prob;
    r = '0;
    case (px.mode)
      MODE_ADD: begin
        if (stored_count < TABLE_DEPTH) begin
          sample_mirror[stored_count] = {px.hue, px.saturation, px.brightness};
          stored_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      MODE_CLEAR: stored_count = 0;
      MODE_CLASSIFY: begin
        best = filter_len << 8;
        for (int k = 0; k < stored_count; k++) begin
          d = w_hue * chan_diff(px.hue, sample_mirror[k].hue)
            + w_sat * chan_diff(px.saturation, sample_mirror[k].saturation)
            + w_val * chan_diff(px.brightness, sample_mirror[k].brightness);
          if (d < best) best = d;
        end
        mind = best >> 8;
        if (mind >= filter_len) begin
          mind = filter_len;
          prob = 0;
        end else begin
          prob = (64'(filter_len - mind) << 16) / 64'(filter_len);
        end
        r.selected     = (prob > 64'(px.random_fraction));
        r.probability  = 17'(prob);
        r.min_distance = 13'(mind);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] mode, input int h, input int s,
                                         input int v, input int rnd);
    in_item_t it;
    it.mode            = mode;
    it.hue             = 8'(h);
    it.saturation      = 8'(s);
    it.brightness      = 8'(v);
    it.random_fraction = 16'(rnd);
    return it;
  endfunction

  function automatic logic [RND_W-1:0] draw_fraction();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return RND_W'($urandom);
  endfunction

  function automatic in_item_t any_item(input logic [1:0] mode);
    return make_item(mode, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                     draw_fraction());
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] c, input int spread);
    int x;
    x = int'(c) + int'($urandom_range(2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return 8'(x);
  endfunction

  // Pick a pixel close to a stored sample most of the time.
  function automatic in_item_t pixel_near(input int spread);
    in_item_t it;
    hsv_t     base;
    it = any_item(MODE_CLASSIFY);
    if (stored_count != 0 && $urandom_range(99) < 75) begin
      base          = sample_mirror[$urandom_range(stored_count - 1)];
      it.hue        = jitter(base.hue, spread);
      it.saturation = jitter(base.saturation, spread);
      it.brightness = jitter(base.brightness, spread);
    end
    return it;
  endfunction

  task automatic table_row(input logic [1:0] mode, input int h, input int s, input int v,
                           input int rnd, input bit typed, input int sel, input int prob,
                           input int mind, input int full);
    directed_row_t row;
    row.stim               = make_item(mode, h, s, v, rnd);
    row.typed              = typed;
    row.want.selected      = 1'(sel);
    row.want.probability   = PROB_W'(prob);
    row.want.min_distance  = FILTER_W'(mind);
    row.want.table_full    = 1'(full);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer(input in_item_t item, input bit typed, input out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = 0;
    if (!steady) while (gap < 12 && $urandom_range(99) < 24) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = nearest_sample_outcome(item);
    pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
    if (item.mode != MODE_RESERVED) accepted_items++;
    @(negedge clk);
  endtask

  task automatic send(input in_item_t item);
    offer(item, 1'b0, '0);
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic await_idle();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= FILTER_W'(value);
    case (idx)
      REG_WEIGHT_HUE:        w_hue = value & 12'hFFF;
      REG_WEIGHT_SATURATION: w_sat = value & 12'hFFF;
      REG_WEIGHT_VALUE:      w_val = value & 12'hFFF;
      REG_FILTER_SIZE: begin
        filter_len = value & 13'h1FFF;
        if (filter_len == 0) filter_len = 1;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input int unsigned wh, input int unsigned ws,
                              input int unsigned wv, input int unsigned fs);
    write_reg(REG_WEIGHT_HUE, wh);
    write_reg(REG_WEIGHT_SATURATION, ws);
    write_reg(REG_WEIGHT_VALUE, wv);
    write_reg(REG_FILTER_SIZE, fs);
    cfg_we <= 1'b0;
  endtask

  // Clear, overfill the table, then classify against the full set.
  task automatic fill_table();
    send(any_item(MODE_CLEAR));
    repeat (TABLE_DEPTH + $urandom_range(1, 4)) send(any_item(MODE_ADD));
    repeat ($urandom_range(1, 4)) send(pixel_near($urandom_range(8)));
  endtask

  task automatic sample_set();
    int n;
    int spread;
    if ($urandom_range(99) < 40) send(any_item(MODE_CLEAR));
    n = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    repeat (n) begin
      if (stored_count != 0 && $urandom_range(99) < 30) begin
        in_item_t it;
        it      = pixel_near(20);
        it.mode = MODE_ADD;
        send(it);
      end else begin
        send(any_item(MODE_ADD));
      end
    end
    case ($urandom_range(5))
      0: spread = 0;
      1: spread = 1;
      2: spread = 3;
      3: spread = 8;
      4: spread = 30;
      default: spread = 255;
    endcase
    repeat ($urandom_range(1, 10)) send(pixel_near(spread));
  endtask

  initial begin
    int unsigned budget;
    int          pick;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    // empty table, reserved mode, then the corners of the default setting
    table_row(MODE_CLASSIFY, 0, 0, 0, 0, 1, 0, 0, 50, 0);
    table_row(MODE_RESERVED, 255, 255, 255, 'hFFFF, 1, 0, 0, 0, 0);
    table_row(MODE_CLEAR, 255, 255, 255, 'hFFFF, 1, 0, 0, 0, 0);
    table_row(MODE_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    table_row(MODE_ADD, 255, 255, 255, 'hFFFF, 1, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 0, 0, 0, 0, 1, 1, 65536, 0, 0);
    table_row(MODE_CLASSIFY, 255, 255, 255, 'hFFFF, 1, 1, 65536, 0, 0);
    table_row(MODE_CLASSIFY, 0, 0, 1, 'hFFFF, 0, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 0, 0, 49, 0, 0, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 0, 0, 50, 0, 0, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 128, 128, 128, 0, 0, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 10, 20, 5, 'h8000, 0, 0, 0, 0, 0);
    table_row(MODE_ADD, 'h55, 'hAA, 'h55, 'h1234, 1, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 'hAA, 'h55, 'hAA, 'h0001, 0, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 'h50, 'hA5, 'h5A, 'h1234, 0, 0, 0, 0, 0);
    table_row(MODE_RESERVED, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 'h55, 'hAA, 'h55, 'hFFFF, 1, 1, 65536, 0, 0);
    table_row(MODE_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 0, 0, 0, 0, 1, 0, 0, 50, 0);
    table_row(MODE_ADD, 'h80, 'h7F, 'h01, 'hFFFF, 1, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 'h7F, 'h80, 'hFE, 'h7FFF, 0, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 'h81, 'h7E, 'h00, 'h8000, 0, 0, 0, 0, 0);
    // hue difference does not wrap around
    table_row(MODE_ADD, 'h02, 'h40, 'h40, 0, 1, 0, 0, 0, 0);
    table_row(MODE_CLASSIFY, 'hFE, 'h40, 'h40, 'hAAAA, 0, 0, 0, 0, 0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) offer(directed_rows[i].stim, directed_rows[i].typed,
                                     directed_rows[i].want);

    for (int ph = 0; ph < 8; ph++) begin
      await_idle();
      case (ph)
        0: program_regs(256, 256, 256, 50);
        1: program_regs(0, 0, 0, 0);
        2: program_regs(4095, 4095, 4095, 8191);
        3: program_regs(64, 512, 128, 200);
        4: program_regs(1, 1, 1, 1);
        5: program_regs($urandom_range(2560), $urandom_range(2560), $urandom_range(2560),
                        $urandom_range(1, 8191));
        6: program_regs(2560, 2560, 2560, 8191);
        default: program_regs($urandom_range(4095), $urandom_range(4095),
                              $urandom_range(4095), $urandom_range(1, 400));
      endcase
      steady = (ph == 3);
      budget = accepted_items + PHASE_ITEMS;
      if (ph == 0) fill_table();
      while (accepted_items < budget) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          repeat ($urandom_range(1, 6)) send(any_item(2'($urandom_range(3))));
        end else if (pick < 16) begin
          fill_table();
        end else if (pick < 22 && !steady) begin
          await_idle();
        end else begin
          sample_set();
        end
      end
    end
    steady = 1'b0;

    await_idle();
    repeat (40) @(negedge clk);
    if (fails == 0) begin
      $display("PASS hsv_nearest_sample_pixel_classifier_unit");
    end else begin
      $display("FAIL hsv_nearest_sample_pixel_classifier_unit");
    end
    $finish;
  end

  // Output stall: random, off during the steady phase, one long hold-off.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no expectation pending");
        fails++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_data.selected !== want.selected) begin
          $error("selected: expected %0d, got %0d", want.selected, out_data.selected);
          fails++;
        end
        if (out_data.probability !== want.probability) begin
          $error("probability: expected %0d, got %0d", want.probability,
                 out_data.probability);
          fails++;
        end
        if (out_data.min_distance !== want.min_distance) begin
          $error("min_distance: expected %0d, got %0d", want.min_distance,
                 out_data.min_distance);
          fails++;
        end
        if (out_data.table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, out_data.table_full);
          fails++;
        end
      end
    end
  end

endmodule
